// ===== rtl/tll_pkg.sv =====
// tll_pkg: shared constants, types and lookup functions of the toy language lexer
// no dependencies; imported by every lexer module and the checker

package tll_pkg;

   localparam int WINDOW_CHARS = 8;
   localparam int OFFSET_BITS  = 16;
   localparam int FILL_BITS    = $clog2(WINDOW_CHARS + 1);
   localparam int WIN_IDX_BITS = $clog2(WINDOW_CHARS);

   localparam int LIT_COUNT     = 10;
   localparam int LIT_CHARS     = 6;
   localparam int LIT_IDX_BITS  = 4;
   localparam int LIT_LEN_BITS  = 3;
   localparam int OP1_SLOT      = 8;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   localparam logic [4:0] KIND_EOF      = 5'd0;
   localparam logic [4:0] KIND_IDENT    = 5'd1;
   localparam logic [4:0] KIND_STRING   = 5'd2;
   localparam logic [4:0] KIND_NUMBER   = 5'd3;
   localparam logic [4:0] KIND_ASSIGN   = 5'd4;
   localparam logic [4:0] KIND_EQ       = 5'd5;
   localparam logic [4:0] KIND_LE       = 5'd6;
   localparam logic [4:0] KIND_GE       = 5'd7;
   localparam logic [4:0] KIND_FUNC     = 5'd8;
   localparam logic [4:0] KIND_IF       = 5'd9;
   localparam logic [4:0] KIND_WHILE    = 5'd10;
   localparam logic [4:0] KIND_AND      = 5'd11;
   localparam logic [4:0] KIND_OR       = 5'd12;
   localparam logic [4:0] KIND_LPAREN   = 5'd13;
   localparam logic [4:0] KIND_RPAREN   = 5'd14;
   localparam logic [4:0] KIND_LBRACKET = 5'd15;
   localparam logic [4:0] KIND_RBRACKET = 5'd16;
   localparam logic [4:0] KIND_COMMA    = 5'd17;
   localparam logic [4:0] KIND_PLUS     = 5'd18;
   localparam logic [4:0] KIND_MINUS    = 5'd19;
   localparam logic [4:0] KIND_STAR     = 5'd20;
   localparam logic [4:0] KIND_SLASH    = 5'd21;
   localparam logic [4:0] KIND_OUTPUT   = 5'd22;
   localparam logic [4:0] KIND_INPUT    = 5'd23;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN      = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   localparam logic [1:0] MATCH_NO   = 2'd0;
   localparam logic [1:0] MATCH_HIT  = 2'd1;
   localparam logic [1:0] MATCH_WAIT = 2'd2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_POINT  = 8'h2E;

   typedef logic [WINDOW_CHARS-1:0][7:0] window_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [1:0]  error;
      logic        last;
   } result_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic discard;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic error_seen;
      logic fill_empty;
      logic step_emits;
      logic step_ends;
      logic step_discards;
      logic discard_emits;
      logic pend_valid;
      logic emit_ok;
      logic out_free;
   } status_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // fixed literals, left aligned, first character in the top byte
   function automatic logic [8*LIT_CHARS-1:0] lit_text(logic [LIT_IDX_BITS-1:0] idx);
      logic [8*LIT_CHARS-1:0] text;
      case (idx)
         4'd0: text = {"if", 32'h0};
         4'd1: text = {"while", 8'h0};
         4'd2: text = {"or", 32'h0};
         4'd3: text = {"and", 24'h0};
         4'd4: text = {"func", 16'h0};
         4'd5: text = {"==", 32'h0};
         4'd6: text = {"<=", 32'h0};
         4'd7: text = {">=", 32'h0};
         4'd8: text = "output";
         4'd9: text = {"input", 8'h0};
         default: text = '0;
      endcase
      return text;
   endfunction

   function automatic logic [LIT_LEN_BITS-1:0] lit_len(logic [LIT_IDX_BITS-1:0] idx);
      logic [LIT_LEN_BITS-1:0] len;
      case (idx)
         4'd0: len = 3'd2;
         4'd1: len = 3'd5;
         4'd2: len = 3'd2;
         4'd3: len = 3'd3;
         4'd4: len = 3'd4;
         4'd5: len = 3'd2;
         4'd6: len = 3'd2;
         4'd7: len = 3'd2;
         4'd8: len = 3'd6;
         4'd9: len = 3'd5;
         default: len = 3'd1;
      endcase
      return len;
   endfunction

   function automatic logic [4:0] lit_kind(logic [LIT_IDX_BITS-1:0] idx);
      logic [4:0] kind;
      case (idx)
         4'd0: kind = KIND_IF;
         4'd1: kind = KIND_WHILE;
         4'd2: kind = KIND_OR;
         4'd3: kind = KIND_AND;
         4'd4: kind = KIND_FUNC;
         4'd5: kind = KIND_EQ;
         4'd6: kind = KIND_LE;
         4'd7: kind = KIND_GE;
         4'd8: kind = KIND_OUTPUT;
         4'd9: kind = KIND_INPUT;
         default: kind = KIND_EOF;
      endcase
      return kind;
   endfunction

   // keywords 0 to 4 need a separator after them; output and input do not
   function automatic logic lit_space(logic [LIT_IDX_BITS-1:0] idx);
      return idx < 4'd5;
   endfunction

   function automatic logic [1:0] match_lit(window_type win, logic [FILL_BITS-1:0] fill,
                                            logic [LIT_IDX_BITS-1:0] idx);
      logic [8*LIT_CHARS-1:0] text;
      logic [LIT_LEN_BITS-1:0] len;
      logic ok;
      logic [1:0] res;
      text = lit_text(idx);
      len  = lit_len(idx);
      ok   = 1'b1;
      for (int i = 0; i < LIT_CHARS; i++) begin
         if ((i < len) && (i < fill) && (win[i] != text[8*LIT_CHARS-1-8*i -: 8])) begin
            ok = 1'b0;
         end
      end
      if (!ok) begin
         res = MATCH_NO;
      end else if (fill < FILL_BITS'(len)) begin
         res = MATCH_WAIT;
      end else if (!lit_space(idx)) begin
         res = MATCH_HIT;
      end else if (fill == FILL_BITS'(len)) begin
         res = MATCH_WAIT;
      end else begin
         res = is_space(win[WIN_IDX_BITS'(len)]) ? MATCH_HIT : MATCH_NO;
      end
      return res;
   endfunction

   // single character operators: {hit, kind}
   function automatic logic [5:0] op1_match(logic [7:0] c);
      logic [5:0] res;
      case (c)
         "=":     res = {1'b1, KIND_ASSIGN};
         "(":     res = {1'b1, KIND_LPAREN};
         ")":     res = {1'b1, KIND_RPAREN};
         "[":     res = {1'b1, KIND_LBRACKET};
         "]":     res = {1'b1, KIND_RBRACKET};
         ",":     res = {1'b1, KIND_COMMA};
         "+":     res = {1'b1, KIND_PLUS};
         "-":     res = {1'b1, KIND_MINUS};
         "*":     res = {1'b1, KIND_STAR};
         "/":     res = {1'b1, KIND_SLASH};
         default: res = {1'b0, KIND_EOF};
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/tll_req_if.sv =====
// tll_req_if: text byte channel of the lexer, valid/ready handshake
// no dependencies

interface tll_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

// ===== rtl/tll_rsp_if.sv =====
// tll_rsp_if: token channel of the lexer, valid/ready handshake
// no dependencies

interface tll_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic [1:0]  error_code;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_offset,
                   output token_length, output error_code, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input start_offset,
                   input token_length, input error_code, input last_of_run,
                   output ready);
endinterface

// ===== rtl/tll_ctrl.sv =====
// tll_ctrl: sequencer of the lexer, one scan step per cycle unless an emitting step waits for the output
// depends on tll_pkg (command and status types)

module tll_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output tll_pkg::cmd_type    cmd,
   input  tll_pkg::status_type sts
);
   import tll_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_START   = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_DISCARD = 3'd3;
   localparam logic [2:0] ST_FLUSH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = sts.error_seen ? ST_FLUSH : ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.fill_empty) begin
               state_in = ST_FLUSH;
            end else if (!sts.step_emits || sts.emit_ok) begin
               cmd.step = 1'b1;
               if (sts.step_discards) begin
                  state_in = ST_DISCARD;
               end else if (sts.step_ends) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_DISCARD: begin
            if (!sts.discard_emits || sts.emit_ok) begin
               cmd.discard = 1'b1;
               state_in    = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/tll_datapath.sv =====
// tll_datapath: lookahead window, token matching, scan state and result registers
// depends on tll_pkg (types, literal tables, character classes)

module tll_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tll_pkg::cmd_type    cmd,
   input  logic [7:0]          req_character,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output tll_pkg::result_type rsp_data,
   output tll_pkg::status_type sts
);
   import tll_pkg::*;

   localparam logic [2:0] M_IDLE   = 3'd0;
   localparam logic [2:0] M_IDENT  = 3'd1;
   localparam logic [2:0] M_INT    = 3'd2;
   localparam logic [2:0] M_FRAC   = 3'd3;
   localparam logic [2:0] M_STRING = 3'd4;

   window_type             win_ff, win_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tstart_ff, tstart_in;
   logic [2:0]             mode_ff, mode_in;
   logic                   qd_ff, qd_in;
   logic                   err_ff, err_in;
   logic [15:0]            rl_ff, rl_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_zero_ff, last_zero_in;
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic [7:0]             front;
   logic [OFFSET_BITS-1:0] front_off;
   logic [15:0]            run_len_inc;
   logic [5:0]             op1;
   logic [1:0]             lit_st [LIT_COUNT];
   logic                   tf_done;
   logic [1:0]             tf_state;
   logic [4:0]             tf_kind;
   logic [LIT_LEN_BITS-1:0] tf_len;

   logic                   d_emit, d_end, d_disc, d_new, d_count, d_ts, d_quote;
   logic [LIT_LEN_BITS-1:0] d_drop;
   logic [2:0]             d_mode;
   logic [15:0]            d_rl;
   result_type             d_res;

   logic [FILL_BITS-1:0]   wr_fill;
   logic                   new_text;
   logic                   emit_now;
   result_type             emit_res;
   logic                   out_free;
   logic                   emit_ok;

   assign front       = win_ff[0];
   assign front_off   = pos_ff - OFFSET_BITS'(fill_ff);
   assign run_len_inc = (rl_ff == LEN_MAX) ? rl_ff : rl_ff + 16'd1;
   assign op1         = op1_match(front);

   always_comb begin
      for (int k = 0; k < LIT_COUNT; k++) begin
         lit_st[k] = match_lit(win_ff, fill_ff, LIT_IDX_BITS'(k));
      end
   end

   // first hit or wait decides: literals 0-7, then operators, then output and input
   always_comb begin
      tf_done  = 1'b0;
      tf_state = MATCH_NO;
      tf_kind  = KIND_EOF;
      tf_len   = '0;
      for (int k = 0; k < OP1_SLOT; k++) begin
         if (!tf_done && (lit_st[k] != MATCH_NO)) begin
            tf_done  = 1'b1;
            tf_state = lit_st[k];
            tf_kind  = lit_kind(LIT_IDX_BITS'(k));
            tf_len   = lit_len(LIT_IDX_BITS'(k));
         end
      end
      if (!tf_done && op1[5]) begin
         tf_done  = 1'b1;
         tf_state = MATCH_HIT;
         tf_kind  = op1[4:0];
         tf_len   = LIT_LEN_BITS'(1);
      end
      for (int k = OP1_SLOT; k < LIT_COUNT; k++) begin
         if (!tf_done && (lit_st[k] != MATCH_NO)) begin
            tf_done  = 1'b1;
            tf_state = lit_st[k];
            tf_kind  = lit_kind(LIT_IDX_BITS'(k));
            tf_len   = lit_len(LIT_IDX_BITS'(k));
         end
      end
   end

   // one scan step on the front byte
   always_comb begin
      d_emit       = 1'b0;
      d_end        = 1'b0;
      d_disc       = 1'b0;
      d_new        = 1'b0;
      d_count      = 1'b0;
      d_ts         = 1'b0;
      d_quote      = 1'b0;
      d_drop       = '0;
      d_mode       = mode_ff;
      d_rl         = '0;
      d_res.kind   = KIND_EOF;
      d_res.start  = 16'(tstart_ff);
      d_res.length = rl_ff;
      d_res.error  = ERR_NONE;
      d_res.last   = 1'b0;
      case (mode_ff)
         M_IDENT: begin
            if (is_alpha(front) || is_digit(front)) begin
               d_drop  = LIT_LEN_BITS'(1);
               d_count = 1'b1;
            end else begin
               d_emit     = 1'b1;
               d_res.kind = KIND_IDENT;
               d_mode     = M_IDLE;
            end
         end
         M_INT, M_FRAC: begin
            if (is_digit(front)) begin
               d_drop  = LIT_LEN_BITS'(1);
               d_count = 1'b1;
            end else if ((front == CH_POINT) && (mode_ff == M_INT)) begin
               d_drop  = LIT_LEN_BITS'(1);
               d_count = 1'b1;
               d_mode  = M_FRAC;
            end else begin
               d_emit     = 1'b1;
               d_res.kind = KIND_NUMBER;
               d_mode     = M_IDLE;
            end
         end
         M_STRING: begin
            if (front == CH_NUL) begin
               d_emit      = 1'b1;
               d_res.error = ERR_UNTERMINATED;
               d_disc      = 1'b1;
            end else begin
               d_drop  = LIT_LEN_BITS'(1);
               d_count = 1'b1;
               if (front == (qd_ff ? CH_DQUOTE : CH_SQUOTE)) begin
                  d_emit       = 1'b1;
                  d_res.kind   = KIND_STRING;
                  d_res.length = run_len_inc;
                  d_mode       = M_IDLE;
               end
            end
         end
         default: begin
            if (is_space(front)) begin
               d_drop = LIT_LEN_BITS'(1);
            end else if (front == CH_NUL) begin
               d_emit       = 1'b1;
               d_res.start  = 16'(front_off);
               d_res.length = '0;
               d_new        = 1'b1;
               d_end        = 1'b1;
            end else if (tf_state == MATCH_WAIT) begin
               d_end = 1'b1;
            end else if (tf_state == MATCH_HIT) begin
               d_emit       = 1'b1;
               d_res.kind   = tf_kind;
               d_res.start  = 16'(front_off);
               d_res.length = 16'(tf_len);
               d_drop       = tf_len;
            end else begin
               d_ts = 1'b1;
               if (is_alpha(front)) begin
                  d_mode = M_IDENT;
               end else if (is_digit(front)) begin
                  d_mode = M_INT;
               end else if ((front == CH_DQUOTE) || (front == CH_SQUOTE)) begin
                  d_quote = 1'b1;
                  d_mode  = M_STRING;
                  d_drop  = LIT_LEN_BITS'(1);
                  d_rl    = 16'd1;
               end else begin
                  d_emit       = 1'b1;
                  d_res.start  = 16'(front_off);
                  d_res.length = 16'd1;
                  d_res.error  = ERR_UNKNOWN;
                  d_disc       = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      tstart_in    = tstart_ff;
      mode_in      = mode_ff;
      qd_in        = qd_ff;
      err_in       = err_ff;
      rl_in        = rl_ff;
      byte_in      = byte_ff;
      last_zero_in = last_zero_ff;
      new_text     = 1'b0;
      emit_now     = 1'b0;
      emit_res     = d_res;
      wr_fill      = (fill_ff >= FILL_BITS'(WINDOW_CHARS)) ?
                     FILL_BITS'(WINDOW_CHARS - 1) : fill_ff;
      if (cmd.load) begin
         byte_in = req_character;
      end
      if (cmd.start) begin
         if (err_ff) begin
            if (byte_ff == CH_NUL) begin
               emit_now        = 1'b1;
               emit_res.kind   = KIND_EOF;
               emit_res.start  = 16'(pos_ff);
               emit_res.length = '0;
               emit_res.error  = ERR_NONE;
               new_text        = 1'b1;
            end else begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
         end else begin
            win_in[wr_fill[WIN_IDX_BITS-1:0]] = byte_ff;
            fill_in      = wr_fill + FILL_BITS'(1);
            pos_in       = pos_ff + OFFSET_BITS'(1);
            last_zero_in = (byte_ff == CH_NUL);
         end
      end
      if (cmd.step) begin
         win_in   = win_ff >> (8 * d_drop);
         fill_in  = fill_ff - FILL_BITS'(d_drop);
         mode_in  = d_mode;
         emit_now = d_emit;
         new_text = d_new;
         if (d_count) begin
            rl_in = run_len_inc;
         end
         if (d_ts) begin
            tstart_in = front_off;
            rl_in     = d_rl;
         end
         if (d_quote) begin
            qd_in = (front == CH_DQUOTE);
         end
      end
      if (cmd.discard) begin
         err_in  = 1'b1;
         mode_in = M_IDLE;
         if ((fill_ff != '0) && last_zero_ff) begin
            emit_now        = 1'b1;
            emit_res.kind   = KIND_EOF;
            emit_res.start  = 16'(pos_ff - OFFSET_BITS'(1));
            emit_res.length = '0;
            emit_res.error  = ERR_NONE;
            new_text        = 1'b1;
         end else begin
            fill_in = '0;
         end
      end
      if (new_text) begin
         pos_in    = '0;
         fill_in   = '0;
         tstart_in = '0;
         mode_in   = M_IDLE;
         qd_in     = 1'b0;
         err_in    = 1'b0;
         rl_in     = '0;
      end
   end

   // newest result waits in pend until it is known whether more follow
   always_comb begin
      out_free      = !out_valid_ff || rsp_ready;
      emit_ok       = !pend_valid_ff || out_free;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (emit_now) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_in.last  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_res;
      end
      if (cmd.flush) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         pos_ff        <= '0;
         tstart_ff     <= '0;
         mode_ff       <= M_IDLE;
         qd_ff         <= 1'b0;
         err_ff        <= 1'b0;
         rl_ff         <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         tstart_ff     <= tstart_in;
         mode_ff       <= mode_in;
         qd_ff         <= qd_in;
         err_ff        <= err_in;
         rl_ff         <= rl_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      byte_ff      <= byte_in;
      last_zero_ff <= last_zero_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign sts.error_seen    = err_ff;
   assign sts.fill_empty    = (fill_ff == '0);
   assign sts.step_emits    = d_emit;
   assign sts.step_ends     = d_end;
   assign sts.step_discards = d_disc;
   assign sts.discard_emits = (fill_ff != '0) && last_zero_ff;
   assign sts.pend_valid    = pend_valid_ff;
   assign sts.emit_ok       = emit_ok;
   assign sts.out_free      = out_free;

endmodule

// ===== rtl/toy_language_lexer_core.sv =====
// toy_language_lexer_core: top level of the streaming lexer
// depends on tll_pkg, tll_req_if, tll_rsp_if, tll_ctrl, tll_datapath
//
// usage:
// - req_chan carries one text byte per transfer; a zero byte ends the text and
//   the next byte starts a new text at offset 0
// - rsp_chan carries tokens (kind, start offset, length, error code); the last
//   token caused by a byte has last_of_run set, bytes that decide nothing give none
// - one byte at a time: a byte is accepted, written into the window and flushed,
//   with a scan step between for each skipped blank, byte of a running token,
//   token decided, token closed or undecided literal, a further state when the scan
//   empties the window and another for a discard; discarded text is not scanned
// - a token waits in a pending register until the next token of its byte is
//   decided or the byte is flushed, and shows on rsp_chan the cycle after that
// - while the receiver stalls with the output register full, any step that must
//   move the pending token and the flush wait, and req_chan.ready stays low
// - reset (synchronous) empties the window and the result registers and starts
//   a new text at offset 0

module toy_language_lexer_core (
   input logic        clock,
   input logic        reset,
   tll_req_if.sink    req_chan,
   tll_rsp_if.source  rsp_chan
);
   import tll_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic       req_ready;
   logic       rsp_valid;
   result_type rsp_data;

   tll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tll_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_character (req_chan.character),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .sts           (sts)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.token_kind   = rsp_data.kind;
   assign rsp_chan.start_offset = rsp_data.start;
   assign rsp_chan.token_length = rsp_data.length;
   assign rsp_chan.error_code   = rsp_data.error;
   assign rsp_chan.last_of_run  = rsp_data.last;

endmodule

// ===== rtl/tll_checker.sv =====
// tll_checker: port level assertions on the lexer top level, bound to it below
// depends on tll_pkg and toy_language_lexer_core

module tll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  token_kind,
   input logic [15:0] start_offset,
   input logic [15:0] token_length,
   input logic [1:0]  error_code,
   input logic        last_of_run
);
   import tll_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({token_kind, start_offset, token_length, error_code, last_of_run}))
      else $error("token changed while stalled");

   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |-> !req_ready)
      else $error("new byte taken before the run of tokens ended");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("byte taken while the previous one is still scanned");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == KIND_EOF) && (error_code == ERR_NONE)
         |-> last_of_run && (token_length == 16'd0))
      else $error("eof token not last or not empty");

endmodule

bind toy_language_lexer_core tll_checker u_tll_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .token_kind   (rsp_chan.token_kind),
   .start_offset (rsp_chan.start_offset),
   .token_length (rsp_chan.token_length),
   .error_code   (rsp_chan.error_code),
   .last_of_run  (rsp_chan.last_of_run)
);
